// ===== src/lmpt_pkg.sv =====
// shared types, codes and constants of the lamp matrix persistence tracker
`default_nettype none
package lmpt_pkg;

	localparam int MATRIX_DIM   = 8;
	localparam int LAMPS        = MATRIX_DIM * MATRIX_DIM;
	localparam int IDX_W        = $clog2(LAMPS);
	localparam int HIST_W       = 8;
	localparam int NUM_ROWS_DEF = 8;
	localparam int NUM_COLS_DEF = 8;

	localparam logic [1:0] CMD_ROW  = 2'd0;
	localparam logic [1:0] CMD_COL  = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	// top two history bits before a shift
	localparam logic [1:0] TOP_OFF_TO_ON = 2'b10;
	localparam logic [1:0] TOP_ON_TO_OFF = 2'b01;

	typedef struct packed {
		logic [1:0]            command;
		logic [MATRIX_DIM-1:0] mask_value;
	} in_beat_t;

	typedef struct packed {
		logic [IDX_W-1:0] lamp_index;
		logic             lamp_on;
		logic             last_event;
	} out_beat_t;

	typedef struct packed {
		logic             load_row;
		logic             load_col;
		logic             tick;
		logic             step;
		logic             flush;
		logic [IDX_W-1:0] idx;
	} ctrl_cmd_t;

	typedef struct packed {
		logic hit;
		logic pend_v;
		logic out_free;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== src/lmpt_ctrl.sv =====
// controller: accepts commands and sequences the change scan after a tick
`default_nettype none
module lmpt_ctrl
	import lmpt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire logic [1:0] command,
	input  wire dp_sts_t   sts,
	output ctrl_cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]       state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             stall;

	assign stall = sts.hit && sts.pend_v && !sts.out_free;

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.idx      = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (command)
						CMD_ROW:  cmd.load_row = 1'b1;
						CMD_COL:  cmd.load_col = 1'b1;
						CMD_TICK: begin
							cmd.tick = 1'b1;
							idx_d    = '0;
							state_d  = ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (!stall) begin
					cmd.step = 1'b1;
					idx_d    = idx_q + IDX_W'(1);
					if (idx_q == IDX_W'(LAMPS - 1))
						state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!sts.pend_v) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/lmpt_datapath.sv =====
// datapath: masks, lamp histories, change vectors, pending event and output register
`default_nettype none
module lmpt_datapath
	import lmpt_pkg::*;
#(
	parameter int NUM_ROWS = NUM_ROWS_DEF,
	parameter int NUM_COLS = NUM_COLS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [MATRIX_DIM-1:0] mask_value,
	input  wire ctrl_cmd_t             cmd,
	output dp_sts_t                    sts,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_beat_t                  out_data
);

	logic [MATRIX_DIM-1:0] row_q, col_q, row_new, col_new;
	logic [HIST_W-1:0]     hist_q [LAMPS];
	logic [LAMPS-1:0]      lit, chg_q, on_q;
	logic [IDX_W-1:0]      pend_idx_q;
	logic                  pend_on_q, pend_v_q;
	out_beat_t             out_q;
	logic                  out_v_q;
	logic                  push;
	out_beat_t             push_beat;

	assign row_new = cmd.load_row ? mask_value : row_q;
	assign col_new = cmd.load_col ? mask_value : col_q;

	// lamps driven by the masks as they stand after this write
	always_comb begin
		lit = '0;
		for (int c = 0; c < MATRIX_DIM; c++) begin
			for (int r = 0; r < MATRIX_DIM; r++) begin
				if (c < NUM_COLS && r < NUM_ROWS)
					lit[c*MATRIX_DIM + r] = col_new[c] & row_new[r];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			chg_q <= '0;
			on_q  <= '0;
			for (int i = 0; i < LAMPS; i++)
				hist_q[i] <= '0;
		end else begin
			if (cmd.load_row)
				row_q <= mask_value;
			if (cmd.load_col)
				col_q <= mask_value;
			for (int i = 0; i < LAMPS; i++) begin
				if (cmd.tick) begin
					hist_q[i] <= hist_q[i] >> 1;
					chg_q[i]  <= (hist_q[i][HIST_W-1 -: 2] == TOP_OFF_TO_ON) ||
						(hist_q[i][HIST_W-1 -: 2] == TOP_ON_TO_OFF);
					on_q[i]   <= hist_q[i][HIST_W-1 -: 2] == TOP_OFF_TO_ON;
				end else if ((cmd.load_row || cmd.load_col) && lit[i]) begin
					hist_q[i][HIST_W-1] <= 1'b1;
				end
			end
		end
	end

	assign sts.hit      = chg_q[cmd.idx];
	assign sts.pend_v   = pend_v_q;
	assign sts.out_free = !out_v_q || out_ready;

	// one event is held back until the next one shows whether it was the last
	always_comb begin
		push                 = 1'b0;
		push_beat.lamp_index = pend_idx_q;
		push_beat.lamp_on    = pend_on_q;
		push_beat.last_event = 1'b0;
		if (cmd.step && sts.hit && pend_v_q)
			push = 1'b1;
		if (cmd.flush) begin
			push                 = 1'b1;
			push_beat.last_event = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.step && sts.hit)
				pend_v_q <= 1'b1;
			else if (cmd.flush)
				pend_v_q <= 1'b0;
			if (push)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && sts.hit) begin
			pend_idx_q <= cmd.idx;
			pend_on_q  <= on_q[cmd.idx];
		end
		if (push)
			out_q <= push_beat;
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// ===== src/lamp_matrix_persistence_tracker.sv =====
// top level of the lamp matrix persistence tracker
// usage:
//   in channel (in_valid/in_ready/in_data): one beat is a row mask write, a column
//   mask write or a frame tick. a mask write lights bit 7 of the history of every
//   lamp at a driven row and column crossing.
//   a tick shifts all 64 histories at once and latches which lamps changed, then a
//   scan walks lamp 0..63 at one lamp per cycle unless the receiver stalls it, and
//   a tick keeps in_ready low until the scan and its final flush are done. unknown
//   commands are taken and do nothing.
//   out channel (out_valid/out_ready/out_data): one beat per change event in
//   ascending lamp order; each event is held back until the next one is found so
//   last_event can be set on the final one. a quiet tick sends no beats.
//   the output register parts the two sides: a waiting beat does not block input
//   once the scan is done. a stalled receiver freezes the scan only when a second
//   event must go out.
//   reset clears masks, all histories, the scan and the output valid flag; the output data is not reset.
`default_nettype none
module lamp_matrix_persistence_tracker
	import lmpt_pkg::*;
#(
	parameter int NUM_ROWS = NUM_ROWS_DEF,
	parameter int NUM_COLS = NUM_COLS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_beat_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_beat_t     out_data
);

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// sequencing: command decode, scan counter, end-of-scan flush
	lmpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (in_data.command),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage and event path
	lmpt_datapath #(
		.NUM_ROWS (NUM_ROWS),
		.NUM_COLS (NUM_COLS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.mask_value (in_data.mask_value),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

`ifndef NO_ASSERTIONS
	// a scan step never pushes into an output register that still holds a beat
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !(sts.hit && sts.pend_v && !sts.out_free))
		else $error("scan step would overwrite a waiting beat");

	// the final flush only happens with an event held back
	a_flush_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> (sts.pend_v && sts.out_free))
		else $error("flush without a pending event or free output");

	// an accepted tick starts the scan, so input is closed on the next cycle
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.command == CMD_TICK) |=> !in_ready)
		else $error("input still open after a tick");

	// no scan or flush work while the block is taking input
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !(cmd.step || cmd.flush))
		else $error("scan activity while idle");
`endif

endmodule
`default_nettype wire
